// ===== src/mlp_inference_argmax_core_assert.svh =====
// assertion macros for the mlp core
`ifndef MLP_INFERENCE_ARGMAX_CORE_ASSERT_SVH
`define MLP_INFERENCE_ARGMAX_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MLP_ASSERT_IMPL(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define MLP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define MLP_ASSERT_IMPL(label, clk, rst_n, cond)
`define MLP_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== src/mlp_pkg.sv =====
package mlp_pkg;

    typedef struct packed {
        logic               command;
        logic [6:0]         weight_index;
        logic signed [15:0] weight_value;
        logic signed [15:0] feature_a;
        logic signed [15:0] feature_b;
    } t_in_item;

    typedef struct packed {
        logic [15:0] score_zero;
        logic [15:0] score_one;
        logic [15:0] score_two;
        logic [15:0] score_three;
        logic [1:0]  winner;
    } t_out_item;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_INFER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_MAC, ST_ACT, ST_SIG, ST_DONE
    } t_state;

    function automatic logic [15:0] sig_entry(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:  v = 16'd32768;
            5'd1:  v = 16'd40793;
            5'd2:  v = 16'd47911;
            5'd3:  v = 16'd53580;
            5'd4:  v = 16'd57724;
            5'd5:  v = 16'd60565;
            5'd6:  v = 16'd62427;
            5'd7:  v = 16'd63615;
            5'd8:  v = 16'd64357;
            5'd9:  v = 16'd64815;
            5'd10: v = 16'd65097;
            5'd11: v = 16'd65269;
            5'd12: v = 16'd65374;
            5'd13: v = 16'd65438;
            5'd14: v = 16'd65476;
            5'd15: v = 16'd65500;
            default: v = 16'd65514;
        endcase
        return v;
    endfunction

endpackage

// ===== src/mlp_front.sv =====
// input queue: two-entry fifo between the port and the engine
module mlp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mlp_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_valid,
    output mlp_pkg::t_in_item o_item,
    input  logic              i_take
);
    import mlp_pkg::*;

    t_in_item r_buf [2];
    logic     r_wp, r_rp;
    logic [1:0] r_cnt;
    logic     w_wr, w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_buf[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_buf[r_wp] <= i_item;
    end
endmodule

// ===== src/mlp_back.sv =====
// engine: one shared mac, weight memory, relu, sigmoid, argmax
module mlp_back #(
    parameter int INPUT_COUNT   = 2,
    parameter int HIDDEN_WIDTH  = 4,
    parameter int HIDDEN_LAYERS = 3,
    parameter int OUTPUT_COUNT  = 4,
    parameter int WORD_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  mlp_pkg::t_in_item  i_item,
    output logic               o_take,
    output logic               o_res_valid,
    output mlp_pkg::t_out_item o_res,
    input  logic               i_res_free
);
    import mlp_pkg::*;
`include "mlp_inference_argmax_core_assert.svh"

    localparam int MAXW = (HIDDEN_WIDTH > INPUT_COUNT) ?
        ((HIDDEN_WIDTH > OUTPUT_COUNT) ? HIDDEN_WIDTH : OUTPUT_COUNT) :
        ((INPUT_COUNT > OUTPUT_COUNT) ? INPUT_COUNT : OUTPUT_COUNT);
    localparam int WCOUNT = INPUT_COUNT * HIDDEN_WIDTH
        + (HIDDEN_LAYERS - 1) * HIDDEN_WIDTH * HIDDEN_WIDTH + HIDDEN_WIDTH * OUTPUT_COUNT;
    localparam int DEPTH = WCOUNT + HIDDEN_LAYERS * HIDDEN_WIDTH + OUTPUT_COUNT;
    localparam int AW = $clog2(DEPTH);
    localparam int NW = (MAXW > 1) ? $clog2(MAXW + 1) : 1;
    localparam int IW = (MAXW > 1) ? $clog2(MAXW) : 1;
    localparam int LW = $clog2(HIDDEN_LAYERS + 1) + 1;
    localparam int ACCW = 2 * WORD_BITS + 8;

    logic signed [15:0] r_mem [DEPTH];
    logic signed [15:0] r_rdata;

    logic signed [WORD_BITS-1:0] r_act [MAXW];
    logic signed [WORD_BITS-1:0] r_nxt [MAXW];
    logic [15:0]                 r_score [MAXW];

    t_state r_state, n_state;
    logic [LW-1:0] r_layer;
    logic [IW-1:0] r_d;
    logic [NW-1:0] r_s;
    logic [AW+LW:0] r_wbase, r_bbase;
    logic signed [ACCW-1:0] r_acc;
    logic signed [ACCW-13:0] r_z;
    logic r_out_valid;
    t_out_item r_out;

    logic          w_out_layer;
    logic [NW-1:0] w_src_n, w_dst_n;
    logic          w_last_d;
    logic          w_res_free;
    assign w_out_layer = (r_layer == LW'(HIDDEN_LAYERS));
    assign w_src_n = (r_layer == '0) ? NW'(INPUT_COUNT) : NW'(HIDDEN_WIDTH);
    assign w_dst_n = w_out_layer ? NW'(OUTPUT_COUNT) : NW'(HIDDEN_WIDTH);
    assign w_last_d = (r_d == IW'(w_dst_n - NW'(1)));
    // output register free now or being emptied this cycle
    assign w_res_free = !r_out_valid || i_res_free;

    // address: weights at base + s*dst + d, bias at bbase + d
    logic [AW+LW:0] w_addr;
    logic [AW+LW:0] w_wa;
    assign w_wa = r_wbase + (AW+LW+1)'(r_s) * (AW+LW+1)'(w_dst_n) + (AW+LW+1)'(r_d);
    always_comb begin
        if (r_state == ST_READ) w_addr = r_bbase + (AW+LW+1)'(r_d);
        else                    w_addr = w_wa;
    end

    assign o_take = (r_state == ST_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.command == CMD_LOAD && i_item.weight_index < 7'(DEPTH))
            r_mem[i_item.weight_index[AW-1:0]] <= i_item.weight_value;
        r_rdata <= r_mem[w_addr[AW-1:0]];
    end

    // sigmoid on the registered sum
    logic [ACCW-13:0] w_mag;
    logic [14:0]      w_m;
    logic [15:0]      w_lo, w_hi, w_sig;
    logic [27:0]      w_prod;
    always_comb begin
        w_mag  = r_z[ACCW-13] ? -r_z : r_z;
        w_m    = (w_mag > (ACCW-12)'(32767)) ? 15'h7fff : w_mag[14:0];
        w_lo   = sig_entry({1'b0, w_m[14:11]});
        w_hi   = sig_entry(5'({1'b0, w_m[14:11]} + 5'd1));
        w_prod = 28'(w_hi - w_lo) * 28'(w_m[10:0]);
        w_sig  = w_lo + 16'(w_prod >> 11);
        if (r_z[ACCW-13]) w_sig = 16'(17'h10000 - {1'b0, w_sig});
    end

    // relu with saturation to the hidden word
    logic signed [WORD_BITS-1:0] w_relu;
    always_comb begin
        if (r_z <= 0) w_relu = '0;
        else if (r_z > (ACCW-12)'((2**(WORD_BITS-1)) - 1))
            w_relu = WORD_BITS'((2**(WORD_BITS-1)) - 1);
        else w_relu = WORD_BITS'(r_z);
    end

    // the registered weight read belongs to source s-1
    logic signed [WORD_BITS+15:0] w_mul;
    logic signed [ACCW-1:0]       w_prodw;
    logic signed [ACCW-1:0]       w_sum;
    assign w_mul   = r_act[IW'(r_s - NW'(1))] * r_rdata;
    assign w_prodw = ACCW'(w_mul);
    assign w_sum   = r_acc + w_prodw;

    logic w_last_s;
    assign w_last_s = (r_s == w_src_n);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (o_take && i_item.command == CMD_INFER) n_state = ST_READ;
            ST_READ: n_state = ST_MAC;
            ST_MAC:  if (w_last_s) n_state = w_out_layer ? ST_SIG : ST_ACT;
            ST_ACT:  n_state = ST_READ;
            ST_SIG:  n_state = w_last_d ? ST_DONE : ST_READ;
            ST_DONE: n_state = w_res_free ? ST_IDLE : ST_DONE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // datapath sequencing
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_layer <= '0;
                r_d <= '0;
                r_s <= '0;
                r_wbase <= '0;
                r_bbase <= (AW+LW+1)'(WCOUNT);
                for (int k = 0; k < MAXW; k++) begin
                    if (k == 0) r_act[k] <= WORD_BITS'(i_item.feature_a);
                    else if (k == 1 && INPUT_COUNT > 1)
                        r_act[k] <= WORD_BITS'(i_item.feature_b);
                    else r_act[k] <= '0;
                end
            end
            ST_READ: begin
                r_s <= '0;
            end
            ST_MAC: begin
                if (r_s == '0) r_acc <= ACCW'(r_rdata) <<< 12;
                else           r_acc <= w_sum;
                if (w_last_s) r_z <= (ACCW-12)'(w_sum >>> 12);
                else          r_s <= r_s + NW'(1);
            end
            ST_ACT: begin
                r_nxt[r_d] <= w_relu;
                if (w_last_d) begin
                    r_d <= '0;
                    r_layer <= r_layer + LW'(1);
                    r_wbase <= r_wbase + (AW+LW+1)'(w_src_n) * (AW+LW+1)'(w_dst_n);
                    r_bbase <= r_bbase + (AW+LW+1)'(w_dst_n);
                    for (int k = 0; k < MAXW; k++)
                        r_act[k] <= (k == int'(r_d)) ? w_relu
                                    : (k < HIDDEN_WIDTH ? r_nxt[k] : '0);
                end else begin
                    r_d <= r_d + IW'(1);
                end
            end
            ST_SIG: begin
                r_score[r_d] <= w_sig;
                r_d <= r_d + IW'(1);
            end
            default: ;
        endcase
    end

    // argmax and output register
    logic [1:0]  w_best;
    logic [15:0] w_bv;
    always_comb begin
        w_best = '0;
        w_bv = '0;
        for (int k = 0; k < OUTPUT_COUNT; k++)
            if (r_score[k] > w_bv) begin
                w_bv = r_score[k];
                w_best = 2'(k);
            end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (r_state == ST_DONE && w_res_free) r_out_valid <= 1'b1;
        else if (i_res_free) r_out_valid <= 1'b0;
        if (r_state == ST_DONE && w_res_free) begin
            r_out.score_zero  <= r_score[0];
            r_out.score_one   <= r_score[1 % MAXW];
            r_out.score_two   <= (OUTPUT_COUNT > 2) ? r_score[2 % MAXW] : '0;
            r_out.score_three <= (OUTPUT_COUNT > 3) ? r_score[3 % MAXW] : '0;
            r_out.winner      <= w_best;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res = r_out;

    `MLP_ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == ST_DONE, r_out_valid)
    `MLP_ASSERT_IMPL(a_no_take_busy, i_clk, i_rst_n, !(o_take && r_state != ST_IDLE))
    `MLP_ASSERT_NEXT(a_read_mac, i_clk, i_rst_n, r_state == ST_READ, r_state == ST_MAC)
endmodule

// ===== src/mlp_inference_argmax_core.sv =====
// channel   | handshake       | payload
// input     | i_push / o_full | i_item  (t_in_item)
// result    | o_empty / i_pop | o_result (t_out_item)
// a load writes one weight entry; an inference steps each output of each
// layer through a bias read, src+1 mac steps and an activation
// reset is synchronous active low and clears the queue and the sequencer
// the weight memory is not cleared; the user must write every entry before
// use; the block itself does not enforce it
// a result waiting in the output register holds the engine in its last step
module mlp_inference_argmax_core #(
    parameter int INPUT_COUNT   = 2,
    parameter int HIDDEN_WIDTH  = 4,
    parameter int HIDDEN_LAYERS = 3,
    parameter int OUTPUT_COUNT  = 4,
    parameter int WORD_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mlp_pkg::t_in_item  i_item,
    output logic               o_full,
    output logic               o_empty,
    input  logic               i_pop,
    output mlp_pkg::t_out_item o_result
);
    import mlp_pkg::*;

    logic     w_valid, w_take, w_rvalid;
    t_in_item w_item;

    // front queue decouples the port from the engine
    mlp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_item(i_item),
        .o_full(o_full), .o_valid(w_valid), .o_item(w_item), .i_take(w_take)
    );

    // back engine holds the result until it is popped
    mlp_back #(
        .INPUT_COUNT(INPUT_COUNT), .HIDDEN_WIDTH(HIDDEN_WIDTH),
        .HIDDEN_LAYERS(HIDDEN_LAYERS), .OUTPUT_COUNT(OUTPUT_COUNT),
        .WORD_BITS(WORD_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .i_item(w_item),
        .o_take(w_take), .o_res_valid(w_rvalid), .o_res(o_result),
        .i_res_free(i_pop)
    );

    assign o_empty = !w_rvalid;
endmodule

// ===== tb/sv/mlp_inference_argmax_core_tb.sv =====
`timescale 1ns / 1ps

module mlp_inference_argmax_core_tb;
    import mlp_pkg::*;

    localparam int STORE_DEPTH   = 72;
    localparam int BIAS_BASE     = 56;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 200;

    // sigmoid table at steps of 0.5, unsigned q0.16
    localparam logic [15:0] SIGMOID_STEPS [17] = '{
        16'd32768, 16'd40793, 16'd47911, 16'd53580, 16'd57724, 16'd60565,
        16'd62427, 16'd63615, 16'd64357, 16'd64815, 16'd65097, 16'd65269,
        16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      i_push;
    t_in_item  i_item;
    logic      o_full;
    logic      o_empty;
    logic      i_pop;
    t_out_item o_result;

    // shadow of the weight store and the scores still to come
    logic signed [15:0] weights [STORE_DEPTH];
    t_out_item          pending_scores [$];

    int  error_count;
    int  idle_cycles;
    bit  hold_receiver;
    bit  burst_mode;

    mlp_inference_argmax_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_item   (i_item),
        .o_full   (o_full),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // sigmoid of a clamped q.12 sum, linear interpolation between table steps
    function automatic logic [15:0] sigmoid_score(input longint z);
        longint mag;
        int     idx;
        longint frac;
        longint lo;
        longint val;
        mag = (z < 0) ? -z : z;
        if (mag > 32767) mag = 32767;
        idx  = int'(mag >> 11);
        frac = mag & 2047;
        lo   = SIGMOID_STEPS[idx];
        val  = lo + (((longint'(SIGMOID_STEPS[idx + 1]) - lo) * frac) >> 11);
        return (z < 0) ? 16'(65536 - val) : 16'(val);
    endfunction

    // full network evaluation over the shadow store
    function automatic t_out_item predict_result(input t_in_item item);
        longint    act [4];
        longint    nxt [4];
        logic [15:0] score [4];
        longint    acc;
        longint    z;
        int        wbase;
        int        bbase;
        int        src_n;
        int        best;
        logic [15:0] best_val;
        t_out_item res;
        wbase = 0;
        bbase = BIAS_BASE;
        src_n = 2;
        act = '{default: 0};
        act[0] = item.feature_a;
        act[1] = item.feature_b;
        for (int layer = 0; layer <= 3; layer++) begin
            for (int d = 0; d < 4; d++) begin
                acc = longint'(weights[bbase + d]) * 4096;
                for (int s = 0; s < src_n; s++)
                    acc += act[s] * longint'(weights[wbase + s * 4 + d]);
                // arithmetic shift floors toward minus infinity
                z = acc >>> 12;
                if (layer == 3) begin
                    score[d] = sigmoid_score(z);
                end else begin
                    if (z < 0) z = 0;
                    if (z > 32767) z = 32767;
                    nxt[d] = z;
                end
            end
            wbase += src_n * 4;
            bbase += 4;
            if (layer != 3) begin
                act = nxt;
                src_n = 4;
            end
        end
        best = 0;
        best_val = 16'd0;
        for (int k = 0; k < 4; k++) begin
            if (score[k] > best_val) begin
                best = k;
                best_val = score[k];
            end
        end
        res.score_zero  = score[0];
        res.score_one   = score[1];
        res.score_two   = score[2];
        res.score_three = score[3];
        res.winner      = 2'(best);
        return res;
    endfunction

    // one transfer into the block; prediction made at acceptance
    task automatic send_item(input t_in_item item);
        i_push <= 1'b1;
        i_item <= item;
        do @(posedge i_clk); while (o_full);
        if (item.command == CMD_LOAD) begin
            if (item.weight_index < STORE_DEPTH) begin
                weights[item.weight_index] = item.weight_value;
            end
        end else begin
            pending_scores.push_back(predict_result(item));
        end
        // bursts with random gaps
        if (!burst_mode && $urandom_range(0, 3) == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic load_weight(input int idx, input logic signed [15:0] val);
        t_in_item item;
        item = '0;
        item.command      = CMD_LOAD;
        item.weight_index = 7'(idx);
        item.weight_value = val;
        item.feature_a    = 16'($urandom);
        item.feature_b    = 16'($urandom);
        send_item(item);
    endtask

    task automatic infer(input logic signed [15:0] fa, input logic signed [15:0] fb);
        t_in_item item;
        item = '0;
        item.command      = CMD_INFER;
        item.weight_index = 7'($urandom);
        item.weight_value = 16'($urandom);
        item.feature_a    = fa;
        item.feature_b    = fb;
        send_item(item);
    endtask

    task automatic wait_drained();
        i_push <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
    endtask

    // random weights mostly small so signals stay in range, some extreme
    function automatic logic signed [15:0] random_word();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($signed(16'($urandom_range(0, 8191))) - 16'sd4096);
        endcase
    endfunction

    task automatic load_all(input int mode);
        for (int i = 0; i < STORE_DEPTH; i++) begin
            case (mode)
                0:       load_weight(i, 16'sh1000);
                1:       load_weight(i, 16'sh7fff);
                2:       load_weight(i, 16'sh8000);
                default: load_weight(i, random_word());
            endcase
        end
    endtask

    task automatic test_directed_extremes();
        load_all(0);
        infer(16'sh0000, 16'sh0000);
        infer(16'sh7fff, 16'sh7fff);
        infer(16'sh8000, 16'sh8000);
        infer(16'sh1000, -16'sh1000);
        // address past the store is ignored
        load_weight(STORE_DEPTH, 16'sh7fff);
        load_weight(127, 16'sh8000);
        infer(16'sh0800, 16'sh0400);
        load_all(1);
        infer(16'sh7fff, 16'sh8000);
        load_all(2);
        infer(16'sh7fff, 16'sh7fff);
        infer(16'sh0000, 16'sh0000);
        wait_drained();
    endtask

    // equal scores keep the first index, all-zero weights give 0.5 each
    task automatic test_ties_and_negative();
        for (int i = 0; i < STORE_DEPTH; i++) load_weight(i, 16'sh0000);
        infer(16'sh1234, -16'sh4321);
        load_weight(BIAS_BASE + 12 + 2, -16'sh7000);
        load_weight(BIAS_BASE + 12 + 3, 16'sh0200);
        infer(16'sh0000, 16'sh0000);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                load_all(3);
                sent += STORE_DEPTH;
            end else if ($urandom_range(0, 2) == 0) begin
                load_weight($urandom_range(0, STORE_DEPTH - 1), random_word());
                sent++;
            end else begin
                infer(($urandom_range(0, 1)) ? 16'($urandom)
                      : 16'($signed(16'($urandom_range(0, 16383))) - 16'sd8192),
                      16'($urandom));
                sent++;
            end
            if ($urandom_range(0, 200) == 0) burst_mode = !burst_mode;
        end
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering inferences
    task automatic test_backpressure();
        hold_receiver = 1'b1;
        burst_mode = 1'b1;
        fork
            begin
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_receiver = 1'b0;
            end
            begin
                for (int i = 0; i < 12; i++) infer(16'($urandom), 16'($urandom));
                i_push <= 1'b0;
            end
        join
        burst_mode = 1'b0;
        wait_drained();
    endtask

    // receiver with its own stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (hold_receiver) begin
            i_pop <= 1'b0;
        end else begin
            i_pop <= ($urandom_range(0, 9) < 7) || (($urandom_range(0, 63)) == 0);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_scores.size() == 0) begin
                $error("result transfer with no inference waiting");
                error_count++;
            end else begin
                want = pending_scores.pop_front();
                if (o_result.score_zero !== want.score_zero) begin
                    $error("score_zero expected %0d actual %0d",
                           want.score_zero, o_result.score_zero);
                    error_count++;
                end
                if (o_result.score_one !== want.score_one) begin
                    $error("score_one expected %0d actual %0d",
                           want.score_one, o_result.score_one);
                    error_count++;
                end
                if (o_result.score_two !== want.score_two) begin
                    $error("score_two expected %0d actual %0d",
                           want.score_two, o_result.score_two);
                    error_count++;
                end
                if (o_result.score_three !== want.score_three) begin
                    $error("score_three expected %0d actual %0d",
                           want.score_three, o_result.score_three);
                    error_count++;
                end
                if (o_result.winner !== want.winner) begin
                    $error("winner expected %0d actual %0d",
                           want.winner, o_result.winner);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        error_count   = 0;
        idle_cycles   = 0;
        hold_receiver = 1'b0;
        burst_mode    = 1'b0;
        i_rst_n       = 1'b0;
        i_push        = 1'b0;
        i_item        = '0;
        weights       = '{default: 0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_ties_and_negative();
        test_backpressure();
        test_random_traffic(1700);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_scores.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== mlp_inference_argmax_core.f =====
+incdir+src
src/mlp_pkg.sv
src/mlp_front.sv
src/mlp_back.sv
src/mlp_inference_argmax_core.sv
tb/sv/mlp_inference_argmax_core_tb.sv
